@@ src/rcfd_pkg.sv @@
// Package for the radio-control channel frame decoder: beat types, status codes and
// the constants of the frame layout and of the raw-to-output channel scaling.
// Depends on nothing; used by rc_channel_frame_decoder.
package rcfd_pkg;

  localparam int unsigned CHANNEL_COUNT = 16;
  localparam int unsigned FRAME_BYTES   = 35;
  localparam int unsigned CHAN_W        = 4;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned POS_W         = 6;

  localparam logic [7:0]       START_BYTE   = 8'h0F;
  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] WORD_END_POS = POS_W'(33);

  // Scaling: out = floor((v*1000 + 1000*1342 + 671 - 353*1000) / 1342).
  localparam int unsigned RAW_LOW   = 353;
  localparam int unsigned RAW_HIGH  = 1695;
  localparam int unsigned RAW_SPAN  = RAW_HIGH - RAW_LOW;
  localparam int unsigned OUT_BASE  = 1000;
  localparam int unsigned CVT_OFS   = OUT_BASE * RAW_SPAN + RAW_SPAN / 2 - RAW_LOW * OUT_BASE;

  // Scaled numerator is below 2^27; the reciprocal with a 38-bit shift is exact for
  // every numerator below 2^27 because its rounding excess is below 2^11.
  localparam int unsigned NUM_W       = 27;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned RECIP_W     = 28;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + RAW_SPAN - 1) / RAW_SPAN;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  typedef enum logic [1:0] {
    STAT_GOOD      = 2'd0,
    STAT_BAD_START = 2'd1,
    STAT_BAD_CSUM  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_begin;
  } in_beat_t;

  typedef struct packed {
    status_e              status;
    logic [CHAN_W-1:0]    channel_index;
    logic [VALUE_W-1:0]   scaled_value;
    logic                 last;
  } out_beat_t;

endpackage

@@ src/rc_channel_frame_decoder.sv @@
// Radio-control channel frame decoder: takes a 35-byte frame one byte per beat.
// The first result beat is registered once byte 34 is accepted and busy is set; a
// channel word is scaled in two registered steps after its low byte arrives.
// Throughput: one input beat per cycle, except that input is held off while the
// end-of-frame report drains (16 beats for a good frame, 1 for a bad one).
// Reset (rst_ni, async, active low) clears all control state; the channel store is not reset.
module rc_channel_frame_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcfd_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcfd_pkg::out_beat_t out_data_o
);

  // ---------------------------------------------------------------------------
  // Frame tracking state. The position counter and running XOR are updated on each
  // accepted beat; the start check at byte 0, a channel word's high byte at odd bytes.
  // ---------------------------------------------------------------------------
  logic [rcfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       start_ok_q, start_ok_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 hi_q, hi_d;

  logic                       in_fire;
  logic [rcfd_pkg::POS_W-1:0] pos;
  logic [7:0]                 xor_next;
  logic [rcfd_pkg::CHAN_W-1:0] word_ch;
  logic                       word_done;
  logic                       frame_end;

  // Conversion pipeline: numerator register, then quotient register, then store write.
  logic                         num_vld_q, num_vld_d;
  logic [rcfd_pkg::NUM_W-1:0]   num_q, num_d;
  logic [rcfd_pkg::CHAN_W-1:0]  num_ch_q, num_ch_d;
  logic                         quo_vld_q;
  logic [rcfd_pkg::VALUE_W-1:0] quo_q, quo_d;
  logic [rcfd_pkg::CHAN_W-1:0]  quo_ch_q;
  logic [rcfd_pkg::PROD_W-1:0]  prod;

  logic [rcfd_pkg::VALUE_W-1:0] chan_mem [rcfd_pkg::CHANNEL_COUNT];

  // Report sequencer and output register.
  logic                        busy_q, busy_d;
  logic                        bad_q, bad_d;
  rcfd_pkg::status_e           bad_stat_q, bad_stat_d;
  logic [rcfd_pkg::CHAN_W-1:0] cnt_q, cnt_d;
  logic                        out_vld_q, out_vld_d;
  rcfd_pkg::out_beat_t         out_q, out_d;
  logic                        load;
  logic                        report_last;

  // Input is held off for the whole end-of-frame report.
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // frame_begin forces position zero; an out-of-range count also restarts the frame.
  always_comb begin
    pos = in_data_i.frame_begin ? '0 : pos_q;
    if (pos >= rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES)) begin
      pos = '0;
    end
  end

  assign xor_next  = xor_q ^ in_data_i.byte_value;
  // Even positions 2..32 complete a word; its channel is pos/2 - 1.
  assign word_ch   = rcfd_pkg::CHAN_W'(pos[rcfd_pkg::POS_W-1:1] - 1'b1);
  assign word_done = (pos != '0) && (pos < rcfd_pkg::WORD_END_POS) && !pos[0] &&
                     ({1'b0, word_ch} < (rcfd_pkg::CHAN_W + 1)'(rcfd_pkg::CHANNEL_COUNT));
  assign frame_end = in_fire && (pos == rcfd_pkg::LAST_POS);

  always_comb begin
    pos_d      = pos_q;
    start_ok_d = start_ok_q;
    xor_d      = xor_q;
    hi_d       = hi_q;
    num_vld_d  = 1'b0;
    num_ch_d   = word_ch;
    // Scaled numerator v*1000 + offset; a constant multiply, i.e. a few shifted adds.
    num_d      = rcfd_pkg::NUM_W'({hi_q, in_data_i.byte_value} *
                                  rcfd_pkg::NUM_W'(rcfd_pkg::OUT_BASE)) +
                 rcfd_pkg::NUM_W'(rcfd_pkg::CVT_OFS);
    if (in_fire) begin
      if (pos == '0) begin
        start_ok_d = (in_data_i.byte_value == rcfd_pkg::START_BYTE);
        xor_d      = '0;
      end else begin
        xor_d = xor_next;
        if (pos < rcfd_pkg::WORD_END_POS && pos[0]) begin
          hi_d = in_data_i.byte_value;
        end
        num_vld_d = word_done;
      end
      pos_d = (pos == rcfd_pkg::LAST_POS) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      start_ok_q <= 1'b0;
      xor_q      <= '0;
      hi_q       <= '0;
      num_vld_q  <= 1'b0;
      quo_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      start_ok_q <= start_ok_d;
      xor_q      <= xor_d;
      hi_q       <= hi_d;
      num_vld_q  <= num_vld_d;
      quo_vld_q  <= num_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Division by the raw span as a multiply by its scaled reciprocal. The product
  // is registered before the quotient is written to the channel store.
  // ---------------------------------------------------------------------------
  assign prod  = rcfd_pkg::PROD_W'(num_q) *
                 rcfd_pkg::PROD_W'(rcfd_pkg::RECIP_W'(rcfd_pkg::RECIP_MUL));
  assign quo_d = prod[rcfd_pkg::RECIP_SHIFT +: rcfd_pkg::VALUE_W];

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    num_ch_q <= num_ch_d;
    quo_q    <= quo_d;
    quo_ch_q <= num_ch_q;
    if (quo_vld_q) begin
      chan_mem[quo_ch_q] <= quo_q;
    end
  end

  // ---------------------------------------------------------------------------
  // End-of-frame report. Bytes 33 and 34 still follow the last word, so every channel
  // is written before the sequencer reads it.
  // ---------------------------------------------------------------------------
  assign load        = busy_q && (!out_vld_q || out_ready_i);
  assign report_last = bad_q || (cnt_q == rcfd_pkg::CHAN_W'(rcfd_pkg::CHANNEL_COUNT - 1));

  always_comb begin
    busy_d     = busy_q;
    bad_d      = bad_q;
    bad_stat_d = bad_stat_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      if (bad_q) begin
        out_d.status        = bad_stat_q;
        out_d.channel_index = '0;
        out_d.scaled_value  = '0;
      end else begin
        out_d.status        = rcfd_pkg::STAT_GOOD;
        out_d.channel_index = cnt_q;
        out_d.scaled_value  = chan_mem[cnt_q];
      end
      out_d.last = report_last;
      cnt_d      = cnt_q + 1'b1;
      if (report_last) begin
        busy_d = 1'b0;
      end
    end
    // A bad start byte takes priority over a checksum mismatch.
    if (frame_end) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bad_d  = !start_ok_q || (xor_next != '0);
      if (start_ok_q) begin
        bad_stat_d = rcfd_pkg::STAT_BAD_CSUM;
      end else begin
        bad_stat_d = rcfd_pkg::STAT_BAD_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q      <= bad_d;
    bad_stat_q <= bad_stat_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Accepting the final frame byte always starts a report.
  a_frame_end_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> busy_q)
    else $error("frame end did not start a report");

  // No channel write may land while a report is reading the store.
  a_no_write_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !quo_vld_q)
    else $error("channel store written during report");

  // Error results carry zero index and value and close the frame.
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status != rcfd_pkg::STAT_GOOD) |->
      (out_q.channel_index == '0 && out_q.scaled_value == '0 && out_q.last))
    else $error("malformed error beat");

  // A good frame ends exactly on the highest channel.
  a_good_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status == rcfd_pkg::STAT_GOOD) |->
      (out_q.last == (out_q.channel_index ==
                      rcfd_pkg::CHAN_W'(rcfd_pkg::CHANNEL_COUNT - 1))))
    else $error("last mark on wrong channel");
`endif

endmodule
